/* rtl/cqd_pkg.sv */
// Shared types, codes and constants of the call queue dedup engine.
package cqd_pkg;

  // Queue geometry and field widths.
  localparam int NumSlots = 16;
  localparam int IdxW     = $clog2(NumSlots);
  localparam int CntW     = $clog2(NumSlots + 1);
  localparam int KindW    = 8;
  localparam int KeyW     = 32;
  localparam int SenderW  = 24;
  localparam int ActW     = 3;
  localparam int OutcW    = 3;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 5;

  localparam logic [CfgDataW-1:0] ResetDisplayCount = CfgDataW'(12);

  // One queue entry; it is occupied when its kind is nonzero.
  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [KeyW-1:0]    key;
    logic [SenderW-1:0] sender;
  } entry_t;

  // Requested actions.
  typedef enum logic [ActW-1:0] {
    ActInsert  = 3'd0,
    ActCancel  = 3'd1,
    ActDrop    = 3'd2,
    ActRotUp   = 3'd3,
    ActRotDown = 3'd4,
    ActRead    = 3'd5
  } action_e;

  // Reported outcomes.
  typedef enum logic [OutcW-1:0] {
    OcInserted   = 3'd0,
    OcMovedFront = 3'd1,
    OcDupIgnored = 3'd2,
    OcRemoved    = 3'd3,
    OcNotFound   = 3'd4,
    OcDone       = 3'd5,
    OcEmpty      = 3'd6
  } outcome_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgDisplayCount = 1'd0,
    CfgInsertAtHead = 1'd1
  } cfg_reg_e;

  // Command broadcast to every cell; each cell decodes it against its own index.
  // Shift ranges are half open: lo <= index < hi.
  typedef struct packed {
    logic            load_en;
    logic [IdxW-1:0] load_idx;
    logic            shr_en;     // take the entry of the left neighbor
    logic            shl_en;     // take the entry of the right neighbor
    logic [CntW-1:0] lo;
    logic [CntW-1:0] hi;
    logic            clr_en;
    logic [IdxW-1:0] clr_idx;
    logic            trim_en;    // empty every cell at or beyond trim_from
    logic [CntW-1:0] trim_from;
    entry_t          load_data;
  } cell_cmd_t;

endpackage

/* rtl/cqd_cell.sv */
// One queue cell: holds an entry, shifts with its neighbors and compares its key.
module cqd_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [cqd_pkg::IdxW-1:0]  idx_i,
  input  cqd_pkg::cell_cmd_t        cmd_i,
  input  logic [cqd_pkg::KeyW-1:0]  key_i,
  input  cqd_pkg::entry_t           left_i,
  input  cqd_pkg::entry_t           right_i,
  output cqd_pkg::entry_t           entry_o,
  output logic                      match_o
);

  cqd_pkg::entry_t             entry_q, entry_d;
  logic [cqd_pkg::CntW-1:0]    idx_ext;
  logic                        in_range;

  assign idx_ext  = {{(cqd_pkg::CntW - cqd_pkg::IdxW){1'b0}}, idx_i};
  assign in_range = (idx_ext >= cmd_i.lo) && (idx_ext < cmd_i.hi);

  // Next contents of this cell from the broadcast command.
  always_comb begin
    entry_d = entry_q;
    if (cmd_i.trim_en && (idx_ext >= cmd_i.trim_from)) begin
      entry_d.kind = '0;
    end else if (cmd_i.load_en && (idx_i == cmd_i.load_idx)) begin
      entry_d = cmd_i.load_data;
    end else if (cmd_i.shr_en && in_range) begin
      entry_d = left_i;
    end else if (cmd_i.shl_en && in_range) begin
      entry_d = right_i;
    end else if (cmd_i.clr_en && (idx_i == cmd_i.clr_idx)) begin
      entry_d.kind = '0;
    end
  end

  // The whole entry is cleared by reset; a zero kind marks the cell empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;
  assign match_o = (entry_q.key == key_i);

endmodule

/* rtl/cqd_ctrl.sv */
// Sequencer: accepts transactions, scans for keys, drives the cell commands.
module cqd_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cqd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cqd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [cqd_pkg::ActW-1:0]      action_i,
  input  logic [cqd_pkg::KindW-1:0]     call_kind_i,
  input  logic [cqd_pkg::KeyW-1:0]      call_key_i,
  input  logic [cqd_pkg::SenderW-1:0]   sender_id_i,
  input  logic [cqd_pkg::IdxW-1:0]      read_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [cqd_pkg::OutcW-1:0]     outcome_o,
  output logic [cqd_pkg::CntW-1:0]      entry_count_o,
  output logic                          entry_valid_o,
  output logic [cqd_pkg::KindW-1:0]     entry_kind_o,
  output logic [cqd_pkg::KeyW-1:0]      entry_key_o,
  output logic [cqd_pkg::SenderW-1:0]   entry_sender_o,
  input  logic [cqd_pkg::NumSlots-1:0]  match_i,
  input  cqd_pkg::entry_t               rd_entry_i,
  output logic [cqd_pkg::IdxW-1:0]      rd_idx_o,
  output logic [cqd_pkg::KeyW-1:0]      key_o,
  output cqd_pkg::cell_cmd_t            cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StSearch,
    StFetch,
    StExec,
    StReport
  } state_e;

  state_e                         state_q;
  logic [cqd_pkg::CfgDataW-1:0]   dcount_q;
  logic                           head_mode_q;
  logic [cqd_pkg::CntW-1:0]       count_q;
  cqd_pkg::action_e               act_q;
  cqd_pkg::entry_t                e_q;
  logic [cqd_pkg::IdxW-1:0]       ridx_q;
  logic [cqd_pkg::CntW-1:0]       scan_q;
  logic [cqd_pkg::CntW-1:0]       pos_q;
  logic                           found_q;
  cqd_pkg::outcome_e              outcome_q;
  logic                           out_valid_q;
  cqd_pkg::outcome_e              out_outcome_q;
  logic [cqd_pkg::CntW-1:0]       out_count_q;
  logic                           out_hit_q;
  cqd_pkg::entry_t                out_entry_q;

  logic [cqd_pkg::CntW-1:0]       cap, cfg_cap, cap_m1, cnt_m1, p_head;
  logic                           full, accept, rep_hit, report_fire, match_sel;
  cqd_pkg::action_e               eff_act;
  logic [cqd_pkg::IdxW-1:0]       rep_idx;
  cqd_pkg::outcome_e              exec_outc, rep_outc;
  logic [cqd_pkg::CntW-1:0]       exec_count;

  // Clamp a capacity value into 1..NumSlots.
  function automatic logic [cqd_pkg::CntW-1:0] cap_of(logic [cqd_pkg::CfgDataW-1:0] v);
    logic [cqd_pkg::CntW-1:0] c;
    if (v == '0) begin
      c = cqd_pkg::CntW'(1);
    end else if (cqd_pkg::CntW'(v) > cqd_pkg::CntW'(cqd_pkg::NumSlots)) begin
      c = cqd_pkg::CntW'(cqd_pkg::NumSlots);
    end else begin
      c = cqd_pkg::CntW'(v);
    end
    return c;
  endfunction

  assign cap       = cap_of(dcount_q);
  assign cfg_cap   = cap_of(cfg_data_i);
  assign cap_m1    = cap - cqd_pkg::CntW'(1);
  assign cnt_m1    = count_q - cqd_pkg::CntW'(1);
  assign full      = (count_q >= cap);
  assign accept    = in_valid_i && (state_q == StIdle);
  assign match_sel = match_i[scan_q[cqd_pkg::IdxW-1:0]];
  assign key_o     = e_q.key;

  // An insert with a zero kind behaves as a cancel.
  always_comb begin
    eff_act = cqd_pkg::action_e'(action_i);
    if ((eff_act == cqd_pkg::ActInsert) && (call_kind_i == '0)) begin
      eff_act = cqd_pkg::ActCancel;
    end
  end

  // Slot that is reported, and the read port address.
  assign rep_idx = (act_q == cqd_pkg::ActRead) ? ridx_q : '0;
  assign rep_hit = ({1'b0, rep_idx} < count_q);
  assign rd_idx_o = (state_q == StFetch) ?
                    ((act_q == cqd_pkg::ActRotUp) ? '0 : cnt_m1[cqd_pkg::IdxW-1:0]) :
                    rep_idx;
  assign report_fire = (state_q == StReport) && (!out_valid_q || !out_stall_i);
  assign rep_outc = (act_q == cqd_pkg::ActRead) ?
                    (rep_hit ? cqd_pkg::OcDone : cqd_pkg::OcEmpty) : outcome_q;

  assign p_head = found_q ? pos_q : (full ? cap_m1 : count_q);

  // Cell command for the execute cycle and for capacity trims.
  always_comb begin
    cmd_o           = '0;
    cmd_o.load_data = e_q;
    cmd_o.trim_en   = cfg_we_i && (cfg_idx_i == cqd_pkg::CfgDisplayCount);
    cmd_o.trim_from = cfg_cap;
    exec_outc       = cqd_pkg::OcDone;
    exec_count      = count_q;
    if (state_q == StExec) begin
      case (act_q)
        cqd_pkg::ActInsert: begin
          if (found_q && !head_mode_q) begin
            exec_outc = cqd_pkg::OcDupIgnored;
          end else begin
            exec_outc = found_q ? cqd_pkg::OcMovedFront : cqd_pkg::OcInserted;
            if (!found_q && !full) begin
              exec_count = count_q + cqd_pkg::CntW'(1);
            end
            if (head_mode_q) begin
              cmd_o.shr_en   = 1'b1;
              cmd_o.lo       = cqd_pkg::CntW'(1);
              cmd_o.hi       = p_head + cqd_pkg::CntW'(1);
              cmd_o.load_en  = 1'b1;
              cmd_o.load_idx = '0;
            end else if (!full) begin
              cmd_o.load_en  = 1'b1;
              cmd_o.load_idx = count_q[cqd_pkg::IdxW-1:0];
            end else begin
              cmd_o.shl_en   = 1'b1;
              cmd_o.lo       = '0;
              cmd_o.hi       = cap_m1;
              cmd_o.load_en  = 1'b1;
              cmd_o.load_idx = cap_m1[cqd_pkg::IdxW-1:0];
            end
          end
        end
        cqd_pkg::ActCancel: begin
          if (found_q) begin
            exec_outc     = cqd_pkg::OcRemoved;
            exec_count    = cnt_m1;
            cmd_o.shl_en  = 1'b1;
            cmd_o.lo      = pos_q;
            cmd_o.hi      = cnt_m1;
            cmd_o.clr_en  = 1'b1;
            cmd_o.clr_idx = cnt_m1[cqd_pkg::IdxW-1:0];
          end else begin
            exec_outc = cqd_pkg::OcNotFound;
          end
        end
        cqd_pkg::ActDrop: begin
          if (count_q == '0) begin
            exec_outc = cqd_pkg::OcEmpty;
          end else begin
            exec_count    = cnt_m1;
            cmd_o.shl_en  = 1'b1;
            cmd_o.lo      = '0;
            cmd_o.hi      = cnt_m1;
            cmd_o.clr_en  = 1'b1;
            cmd_o.clr_idx = cnt_m1[cqd_pkg::IdxW-1:0];
          end
        end
        cqd_pkg::ActRotUp: begin
          if (count_q == '0) begin
            exec_outc = cqd_pkg::OcEmpty;
          end else begin
            cmd_o.shl_en   = 1'b1;
            cmd_o.lo       = '0;
            cmd_o.hi       = cnt_m1;
            cmd_o.load_en  = 1'b1;
            cmd_o.load_idx = cnt_m1[cqd_pkg::IdxW-1:0];
          end
        end
        cqd_pkg::ActRotDown: begin
          if (count_q == '0) begin
            exec_outc = cqd_pkg::OcEmpty;
          end else begin
            cmd_o.shr_en   = 1'b1;
            cmd_o.lo       = cqd_pkg::CntW'(1);
            cmd_o.hi       = count_q;
            cmd_o.load_en  = 1'b1;
            cmd_o.load_idx = '0;
          end
        end
        default: begin
          exec_outc = cqd_pkg::OcDone;
        end
      endcase
    end
  end

  // State, configuration and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      dcount_q      <= cqd_pkg::ResetDisplayCount;
      head_mode_q   <= 1'b1;
      count_q       <= '0;
      act_q         <= cqd_pkg::ActRead;
      e_q           <= '0;
      ridx_q        <= '0;
      scan_q        <= '0;
      pos_q         <= '0;
      found_q       <= 1'b0;
      outcome_q     <= cqd_pkg::OcDone;
      out_valid_q   <= 1'b0;
      out_outcome_q <= cqd_pkg::OcDone;
      out_count_q   <= '0;
      out_hit_q     <= 1'b0;
      out_entry_q   <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            act_q   <= eff_act;
            e_q     <= '{kind: call_kind_i, key: call_key_i, sender: sender_id_i};
            ridx_q  <= read_index_i;
            scan_q  <= '0;
            found_q <= 1'b0;
            case (eff_act) inside
              cqd_pkg::ActInsert, cqd_pkg::ActCancel: begin
                state_q <= StSearch;
              end
              cqd_pkg::ActRotUp, cqd_pkg::ActRotDown: begin
                state_q <= (count_q != '0) ? StFetch : StExec;
              end
              default: begin
                state_q <= StExec;
              end
            endcase
          end
        end
        StSearch: begin
          if (scan_q >= count_q) begin
            state_q <= StExec;
          end else if (match_sel) begin
            found_q <= 1'b1;
            pos_q   <= scan_q;
            state_q <= StExec;
          end else begin
            scan_q <= scan_q + cqd_pkg::CntW'(1);
          end
        end
        StFetch: begin
          e_q     <= rd_entry_i;
          state_q <= StExec;
        end
        StExec: begin
          count_q   <= exec_count;
          outcome_q <= exec_outc;
          state_q   <= StReport;
        end
        StReport: begin
          if (report_fire) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase

      // The user must write configuration only while the engine is idle; the block itself does not enforce it.
      if (cfg_we_i) begin
        if (cfg_idx_i == cqd_pkg::CfgDisplayCount) begin
          dcount_q <= cfg_data_i;
          if (count_q > cfg_cap) begin
            count_q <= cfg_cap;
          end
        end else begin
          head_mode_q <= cfg_data_i[0];
        end
      end

      // Result register toward the output channel.
      if (report_fire) begin
        out_valid_q   <= 1'b1;
        out_outcome_q <= rep_outc;
        out_count_q   <= count_q;
        out_hit_q     <= rep_hit;
        out_entry_q   <= rep_hit ? rd_entry_i : '0;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o     = (state_q != StIdle);
  assign out_valid_o    = out_valid_q;
  assign outcome_o      = out_outcome_q;
  assign entry_count_o  = out_count_q;
  assign entry_valid_o  = out_hit_q;
  assign entry_kind_o   = out_entry_q.kind;
  assign entry_key_o    = out_entry_q.key;
  assign entry_sender_o = out_entry_q.sender;

endmodule

/* rtl/call_queue_dedup_engine_unit.sv */
// Top level: row of queue cells, slot read port and the sequencer.
// Insert and cancel scan one slot per cycle, stopping at the first match or at
// the entry count; then the sequencer executes and registers the result.
// Rotations of a non-empty list first fetch the moved entry; drop, read, unused
// actions and empty rotations go straight to execute. A new request is taken only
// after the previous result is registered, so a stalled result delays the next
// acceptance. Reset empties every slot at once (no clearing pass), sets display_count to 12 and insert_at_head to 1.
module call_queue_dedup_engine_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cqd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cqd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [cqd_pkg::ActW-1:0]      action_i,
  input  logic [cqd_pkg::KindW-1:0]     call_kind_i,
  input  logic [cqd_pkg::KeyW-1:0]      call_key_i,
  input  logic [cqd_pkg::SenderW-1:0]   sender_id_i,
  input  logic [cqd_pkg::IdxW-1:0]      read_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [cqd_pkg::OutcW-1:0]     outcome_o,
  output logic [cqd_pkg::CntW-1:0]      entry_count_o,
  output logic                          entry_valid_o,
  output logic [cqd_pkg::KindW-1:0]     entry_kind_o,
  output logic [cqd_pkg::KeyW-1:0]      entry_key_o,
  output logic [cqd_pkg::SenderW-1:0]   entry_sender_o
);

  cqd_pkg::entry_t                entries [cqd_pkg::NumSlots];
  logic [cqd_pkg::NumSlots-1:0]   match;
  cqd_pkg::cell_cmd_t             cmd;
  logic [cqd_pkg::KeyW-1:0]       search_key;
  logic [cqd_pkg::IdxW-1:0]       rd_idx;
  cqd_pkg::entry_t                rd_entry;

  // Row of cells, each wired to its two neighbors.
  for (genvar i = 0; i < cqd_pkg::NumSlots; i++) begin : g_cell
    cqd_pkg::entry_t left_e, right_e;

    if (i == 0) begin : g_first
      assign left_e = '0;
    end else begin : g_mid_l
      assign left_e = entries[i-1];
    end

    if (i == cqd_pkg::NumSlots - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_mid_r
      assign right_e = entries[i+1];
    end

    cqd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (cqd_pkg::IdxW'(i)),
      .cmd_i   (cmd),
      .key_i   (search_key),
      .left_i  (left_e),
      .right_i (right_e),
      .entry_o (entries[i]),
      .match_o (match[i])
    );
  end

  // Single read port over the cells for reports and rotations.
  assign rd_entry = entries[rd_idx];

  cqd_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .call_kind_i    (call_kind_i),
    .call_key_i     (call_key_i),
    .sender_id_i    (sender_id_i),
    .read_index_i   (read_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .outcome_o      (outcome_o),
    .entry_count_o  (entry_count_o),
    .entry_valid_o  (entry_valid_o),
    .entry_kind_o   (entry_kind_o),
    .entry_key_o    (entry_key_o),
    .entry_sender_o (entry_sender_o),
    .match_i        (match),
    .rd_entry_i     (rd_entry),
    .rd_idx_o       (rd_idx),
    .key_o          (search_key),
    .cmd_o          (cmd)
  );

endmodule

/* tb/sv/call_queue_dedup_engine_unit_test.sv */
// Self-checking testbench of the call queue dedup engine: directed table, then random traffic.
`timescale 1ns / 1ps

module call_queue_dedup_engine_unit_test;

  // Run control.
  localparam int ClkPeriod     = 8;
  localparam int TimeoutCycles = 400_000;
  localparam int DrainCycles   = 40;
  localparam int HoldCycles    = 300;
  localparam int NumPhases     = 10;
  localparam int PhaseItems    = 100;

  // Action codes the package leaves unnamed; the block treats them as no-ops.
  localparam logic [cqd_pkg::ActW-1:0] ActSpareLo = 3'd6;
  localparam logic [cqd_pkg::ActW-1:0] ActSpareHi = 3'd7;

  // One request to the queue.
  typedef struct packed {
    logic [cqd_pkg::ActW-1:0]    act;
    logic [cqd_pkg::KindW-1:0]   kind;
    logic [cqd_pkg::KeyW-1:0]    key;
    logic [cqd_pkg::SenderW-1:0] sender;
    logic [cqd_pkg::IdxW-1:0]    ridx;
  } call_op_t;

  // One reported result.
  typedef struct packed {
    cqd_pkg::outcome_e           outcome;
    logic [cqd_pkg::CntW-1:0]    count;
    logic                        valid;
    logic [cqd_pkg::KindW-1:0]   kind;
    logic [cqd_pkg::KeyW-1:0]    key;
    logic [cqd_pkg::SenderW-1:0] sender;
  } call_result_t;

  // A row of the directed table: a register write or a request.
  typedef struct {
    bit                           is_cfg;
    cqd_pkg::cfg_reg_e            cfg_sel;
    logic [cqd_pkg::CfgDataW-1:0] cfg_val;
    call_op_t                     op;
    bit                           typed;
    call_result_t                 want;
  } dir_row_t;

  logic                         clk;
  logic                         rst_ni;
  logic                         cfg_we;
  logic [cqd_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [cqd_pkg::CfgDataW-1:0] cfg_data;
  logic                         in_valid;
  logic                         in_stall;
  logic [cqd_pkg::ActW-1:0]     action;
  logic [cqd_pkg::KindW-1:0]    call_kind;
  logic [cqd_pkg::KeyW-1:0]     call_key;
  logic [cqd_pkg::SenderW-1:0]  sender_id;
  logic [cqd_pkg::IdxW-1:0]     read_index;
  logic                         out_valid;
  logic                         out_stall;
  logic [cqd_pkg::OutcW-1:0]    outcome;
  logic [cqd_pkg::CntW-1:0]     entry_count;
  logic                         entry_valid;
  logic [cqd_pkg::KindW-1:0]    entry_kind;
  logic [cqd_pkg::KeyW-1:0]     entry_key;
  logic [cqd_pkg::SenderW-1:0]  entry_sender;

  call_queue_dedup_engine_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .action_i      (action),
    .call_kind_i   (call_kind),
    .call_key_i    (call_key),
    .sender_id_i   (sender_id),
    .read_index_i  (read_index),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .outcome_o     (outcome),
    .entry_count_o (entry_count),
    .entry_valid_o (entry_valid),
    .entry_kind_o  (entry_kind),
    .entry_key_o   (entry_key),
    .entry_sender_o(entry_sender)
  );

  // Shadow copy of the queue and its registers.
  cqd_pkg::entry_t              shadow_slots [cqd_pkg::NumSlots];
  logic [cqd_pkg::CfgDataW-1:0] shadow_display;
  bit                           shadow_head_mode;

  call_result_t pending_results [$];
  dir_row_t     dir_tab [$];
  logic [cqd_pkg::KeyW-1:0] key_pool [8];
  int           mismatch_count = 0;
  int           idle_pct = 33;
  int           stall_pct = 33;
  bit           hold_req = 1'b0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // Watchdog for a hung block.
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("CHECKS FAILED");
    $finish;
  end

  // Capacity as the block uses it: clamped to 1..NumSlots.
  function automatic int cap_now();
    int c;
    c = int'(shadow_display);
    if (c < 1) c = 1;
    if (c > cqd_pkg::NumSlots) c = cqd_pkg::NumSlots;
    return c;
  endfunction

  // Occupied entries form a prefix; the first empty slot ends it.
  function automatic int live_count();
    int c;
    c = cap_now();
    for (int i = 0; i < c; i++) begin
      if (shadow_slots[i].kind == '0) return i;
    end
    return c;
  endfunction

  function automatic int find_key(input int n, input logic [cqd_pkg::KeyW-1:0] key);
    for (int i = 0; i < n; i++) begin
      if (shadow_slots[i].key == key) return i;
    end
    return n;
  endfunction

  // Remove the entry at pos from the first n, closing the gap.
  function automatic void remove_slot(input int pos, input int n);
    for (int i = pos; i + 1 < n; i++) shadow_slots[i] = shadow_slots[i + 1];
    shadow_slots[n - 1] = '0;
  endfunction

  // Put e at the front, shifting n entries back; the last falls off when full.
  function automatic void push_front(input cqd_pkg::entry_t e, input int n, input int c);
    int m;
    m = (n >= c) ? c - 1 : n;
    for (int i = m; i > 0; i--) shadow_slots[i] = shadow_slots[i - 1];
    shadow_slots[0] = e;
  endfunction

  // Append e; when full the head falls off first.
  function automatic void push_back(input cqd_pkg::entry_t e, input int n, input int c);
    if (n >= c) begin
      remove_slot(0, c);
      shadow_slots[c - 1] = e;
    end else begin
      shadow_slots[n] = e;
    end
  endfunction

  // Register write as seen by the shadow; a smaller capacity truncates the list.
  function automatic void apply_cfg(input cqd_pkg::cfg_reg_e sel,
                                    input logic [cqd_pkg::CfgDataW-1:0] val);
    int c;
    if (sel == cqd_pkg::CfgDisplayCount) begin
      shadow_display = val;
      c = cap_now();
      for (int i = c; i < cqd_pkg::NumSlots; i++) shadow_slots[i] = '0;
    end else begin
      shadow_head_mode = val[0];
    end
  endfunction

  // Apply one request to the shadow queue and return the result it yields.
  function automatic call_result_t predict_call(input call_op_t op);
    call_result_t res;
    cqd_pkg::entry_t e;
    cqd_pkg::entry_t moved;
    int c;
    int n;
    int pos;
    int rep;
    logic [cqd_pkg::ActW-1:0] act;
    c = cap_now();
    n = live_count();
    rep = 0;
    act = op.act;
    e.kind = op.kind;
    e.key = op.key;
    e.sender = op.sender;
    res = '0;
    res.outcome = cqd_pkg::OcDone;
    // An insert with kind zero is a cancel.
    if (act == cqd_pkg::ActInsert && op.kind == '0) act = cqd_pkg::ActCancel;
    case (act)
      cqd_pkg::ActInsert: begin
        pos = find_key(n, op.key);
        if (pos < n) begin
          if (shadow_head_mode) begin
            push_front(e, pos, c);
            res.outcome = cqd_pkg::OcMovedFront;
          end else begin
            res.outcome = cqd_pkg::OcDupIgnored;
          end
        end else begin
          if (shadow_head_mode) push_front(e, n, c);
          else push_back(e, n, c);
          res.outcome = cqd_pkg::OcInserted;
        end
      end
      cqd_pkg::ActCancel: begin
        pos = find_key(n, op.key);
        if (pos < n) begin
          remove_slot(pos, n);
          res.outcome = cqd_pkg::OcRemoved;
        end else begin
          res.outcome = cqd_pkg::OcNotFound;
        end
      end
      cqd_pkg::ActDrop: begin
        if (n == 0) res.outcome = cqd_pkg::OcEmpty;
        else remove_slot(0, n);
      end
      cqd_pkg::ActRotUp: begin
        if (n == 0) begin
          res.outcome = cqd_pkg::OcEmpty;
        end else begin
          moved = shadow_slots[0];
          remove_slot(0, n);
          push_back(moved, n - 1, c);
        end
      end
      cqd_pkg::ActRotDown: begin
        if (n == 0) begin
          res.outcome = cqd_pkg::OcEmpty;
        end else begin
          moved = shadow_slots[n - 1];
          shadow_slots[n - 1] = '0;
          push_front(moved, n - 1, c);
        end
      end
      cqd_pkg::ActRead: rep = int'(op.ridx);
      default: ;
    endcase
    n = live_count();
    res.count = cqd_pkg::CntW'(n);
    if (rep < n) begin
      res.valid = 1'b1;
      res.kind = shadow_slots[rep].kind;
      res.key = shadow_slots[rep].key;
      res.sender = shadow_slots[rep].sender;
    end
    if (act == cqd_pkg::ActRead) begin
      if (rep < n) res.outcome = cqd_pkg::OcDone;
      else res.outcome = cqd_pkg::OcEmpty;
    end
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatch_count++;
    $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Result monitor: every accepted result is checked against the oldest prediction.
  always @(posedge clk) begin
    call_result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing pending", {61'd0, outcome}, 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (outcome !== want.outcome) begin
          flag_mismatch("outcome", 64'(outcome), 64'(want.outcome));
        end
        if (entry_count !== want.count) begin
          flag_mismatch("entry_count", 64'(entry_count), 64'(want.count));
        end
        if (entry_valid !== want.valid) begin
          flag_mismatch("entry_valid", 64'(entry_valid), 64'(want.valid));
        end
        if (entry_kind !== want.kind) begin
          flag_mismatch("entry_kind", 64'(entry_kind), 64'(want.kind));
        end
        if (entry_key !== want.key) begin
          flag_mismatch("entry_key", 64'(entry_key), 64'(want.key));
        end
        if (entry_sender !== want.sender) begin
          flag_mismatch("entry_sender", 64'(entry_sender), 64'(want.sender));
        end
      end
    end
  end

  // Receiver: random stalls, and one long hold-off on request.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
      end
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // Offer one transaction, wait for it to be taken and record its prediction.
  // Entered and left at a falling edge.
  task automatic send_op(input call_op_t op, input bit typed, input call_result_t want);
    call_result_t res;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= op.act;
    call_kind <= op.kind;
    call_key <= op.key;
    sender_id <= op.sender;
    read_index <= op.ridx;
    do @(posedge clk); while (in_stall);
    res = predict_call(op);
    if (typed) pending_results.push_back(want);
    else pending_results.push_back(res);
    @(negedge clk);
  endtask

  // Register write, done only once the block has delivered every result.
  task automatic write_cfg(input cqd_pkg::cfg_reg_e sel,
                           input logic [cqd_pkg::CfgDataW-1:0] val);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= sel;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    apply_cfg(sel, val);
  endtask

  function automatic void add_op(input logic [cqd_pkg::ActW-1:0] act,
                                 input logic [cqd_pkg::KindW-1:0] kind,
                                 input logic [cqd_pkg::KeyW-1:0] key,
                                 input logic [cqd_pkg::SenderW-1:0] sender,
                                 input logic [cqd_pkg::IdxW-1:0] ridx, input bit typed,
                                 input call_result_t want);
    dir_row_t r;
    r.is_cfg = 1'b0;
    r.cfg_sel = cqd_pkg::CfgDisplayCount;
    r.cfg_val = '0;
    r.op = '{act, kind, key, sender, ridx};
    r.typed = typed;
    r.want = want;
    dir_tab.push_back(r);
  endfunction

  function automatic void add_cfg(input cqd_pkg::cfg_reg_e sel,
                                  input logic [cqd_pkg::CfgDataW-1:0] val);
    dir_row_t r;
    r.is_cfg = 1'b1;
    r.cfg_sel = sel;
    r.cfg_val = val;
    r.op = '0;
    r.typed = 1'b0;
    r.want = '0;
    dir_tab.push_back(r);
  endfunction

  // Random request; keys mostly come from a small pool so that matches happen.
  function automatic call_op_t rand_op();
    call_op_t op;
    int r;
    r = $urandom_range(99);
    op.kind = cqd_pkg::KindW'($urandom_range(255, 1));
    if ($urandom_range(19) == 0) op.kind = '0;
    else if ($urandom_range(19) == 0) op.kind = '1;
    if (r < 45) op.act = cqd_pkg::ActInsert;
    else if (r < 62) op.act = cqd_pkg::ActCancel;
    else if (r < 70) op.act = cqd_pkg::ActDrop;
    else if (r < 77) op.act = cqd_pkg::ActRotUp;
    else if (r < 84) op.act = cqd_pkg::ActRotDown;
    else if (r < 97) op.act = cqd_pkg::ActRead;
    else if (r < 99) op.act = ActSpareLo;
    else op.act = ActSpareHi;
    if ($urandom_range(99) < 85) op.key = key_pool[$urandom_range(7)];
    else op.key = $urandom;
    op.sender = cqd_pkg::SenderW'($urandom);
    op.ridx = cqd_pkg::IdxW'($urandom_range(cqd_pkg::NumSlots - 1));
    return op;
  endfunction

  // Stimulus.
  initial begin
    call_result_t empty_res;
    call_result_t nf_res;
    call_result_t first_res;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    action = '0;
    call_kind = '0;
    call_key = '0;
    sender_id = '0;
    read_index = '0;
    for (int i = 0; i < cqd_pkg::NumSlots; i++) shadow_slots[i] = '0;
    shadow_display = cqd_pkg::ResetDisplayCount;
    shadow_head_mode = 1'b1;

    empty_res = '{cqd_pkg::OcEmpty, '0, '0, '0, '0, '0};
    nf_res = '{cqd_pkg::OcNotFound, '0, '0, '0, '0, '0};
    first_res = '{cqd_pkg::OcInserted, cqd_pkg::CntW'(1), 1'b1, '1, '1, '1};

    // Empty list: read, drop and both rotations report empty; cancel reports not found.
    add_op(cqd_pkg::ActRead, 8'h00, 32'h0, 24'h0, 4'd0, 1'b1, empty_res);
    add_op(cqd_pkg::ActDrop, 8'h11, 32'h1, 24'h1, 4'd0, 1'b1, empty_res);
    add_op(cqd_pkg::ActRotUp, 8'h22, 32'h2, 24'h2, 4'd0, 1'b1, empty_res);
    add_op(cqd_pkg::ActRotDown, 8'h33, 32'h3, 24'h3, 4'd0, 1'b1, empty_res);
    add_op(cqd_pkg::ActCancel, 8'h44, 32'h5, 24'h5, 4'd0, 1'b1, nf_res);
    // First insert with every field at its maximum.
    add_op(cqd_pkg::ActInsert, 8'hFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 4'hF, 1'b1, first_res);
    add_op(cqd_pkg::ActInsert, 8'h01, 32'h0, 24'h0, 4'd0, 1'b0, '0);
    add_op(cqd_pkg::ActInsert, 8'h80, 32'h1234_5678, 24'hAB_CDEF, 4'd0, 1'b0, '0);
    // Repeat in head mode moves the match to the front with the new contents.
    add_op(cqd_pkg::ActInsert, 8'h5A, 32'h0, 24'h55_AA55, 4'd0, 1'b0, '0);
    // Kind zero acts as cancel.
    add_op(cqd_pkg::ActInsert, 8'h00, 32'hFFFF_FFFF, 24'h0, 4'd0, 1'b0, '0);
    add_op(cqd_pkg::ActRead, 8'h00, 32'h0, 24'h0, 4'hF, 1'b0, '0);
    add_op(cqd_pkg::ActRead, 8'h00, 32'h0, 24'h0, 4'd1, 1'b0, '0);
    add_op(cqd_pkg::ActRotUp, 8'h00, 32'h0, 24'h0, 4'd0, 1'b0, '0);
    add_op(cqd_pkg::ActRotDown, 8'h00, 32'h0, 24'h0, 4'd0, 1'b0, '0);
    add_op(ActSpareLo, 8'h00, 32'h0, 24'h0, 4'd0, 1'b0, '0);
    add_op(ActSpareHi, 8'h00, 32'h0, 24'h0, 4'd0, 1'b0, '0);
    // Tail mode: duplicates are ignored, new entries go to the end.
    add_cfg(cqd_pkg::CfgInsertAtHead, 5'd0);
    add_op(cqd_pkg::ActInsert, 8'h07, 32'h1234_5678, 24'h11_1111, 4'd0, 1'b0, '0);
    add_op(cqd_pkg::ActInsert, 8'h09, 32'hDEAD_BEEF, 24'h22_2222, 4'd0, 1'b0, '0);
    // Capacity of one: the list is truncated, and a full tail insert drops the head.
    add_cfg(cqd_pkg::CfgDisplayCount, 5'd1);
    add_op(cqd_pkg::ActInsert, 8'h0A, 32'hAAAA_0000, 24'h33_3333, 4'd0, 1'b0, '0);
    add_op(cqd_pkg::ActInsert, 8'h0B, 32'hBBBB_0000, 24'h44_4444, 4'd0, 1'b0, '0);
    // Out of range capacities clamp to one and to the slot count.
    add_cfg(cqd_pkg::CfgDisplayCount, 5'd0);
    add_cfg(cqd_pkg::CfgDisplayCount, 5'd31);
    add_cfg(cqd_pkg::CfgInsertAtHead, 5'd1);
    add_op(cqd_pkg::ActInsert, 8'hC3, 32'h0F0F_0F0F, 24'h0F_0F0F, 4'd0, 1'b0, '0);
    add_op(cqd_pkg::ActDrop, 8'h00, 32'h0, 24'h0, 4'd0, 1'b0, '0);
    add_op(cqd_pkg::ActCancel, 8'h00, 32'hBBBB_0000, 24'h0, 4'd0, 1'b0, '0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    // Directed table.
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) write_cfg(dir_tab[i].cfg_sel, dir_tab[i].cfg_val);
      else send_op(dir_tab[i].op, dir_tab[i].typed, dir_tab[i].want);
    end

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: write_cfg(cqd_pkg::CfgDisplayCount, 5'd16);
        1: write_cfg(cqd_pkg::CfgDisplayCount, 5'd1);
        2: write_cfg(cqd_pkg::CfgDisplayCount, 5'd0);
        3: write_cfg(cqd_pkg::CfgDisplayCount, 5'd31);
        default: write_cfg(cqd_pkg::CfgDisplayCount,
                           cqd_pkg::CfgDataW'($urandom_range(31)));
      endcase
      write_cfg(cqd_pkg::CfgInsertAtHead, cqd_pkg::CfgDataW'($urandom_range(1)));
      for (int k = 0; k < 8; k++) key_pool[k] = $urandom;
      key_pool[0] = '0;
      key_pool[1] = '1;
      // One phase runs without any idling on either side.
      if (ph == 3) begin
        idle_pct = 0;
        stall_pct = 0;
      end else begin
        idle_pct = 33;
        stall_pct = 33;
      end
      // One phase starts with a long receiver hold-off so the block backs up.
      if (ph == 5) hold_req = 1'b1;
      for (int it = 0; it < PhaseItems; it++) send_op(rand_op(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/cqd_pkg.sv
rtl/cqd_cell.sv
rtl/cqd_ctrl.sv
rtl/call_queue_dedup_engine_unit.sv
tb/sv/call_queue_dedup_engine_unit_test.sv
